@@ rtl/gfrm_pkg.sv @@
package gfrm_pkg;

  // Field element and pipeline geometry
  localparam int unsigned ELEM_W         = 64;
  localparam int unsigned CELL_BITS      = 8;
  localparam int unsigned NUM_CELLS      = ELEM_W / CELL_BITS;
  // Edges from the accept edge to the edge that takes the result
  localparam int unsigned PIPE_LAT       = NUM_CELLS + 1;

  // Configuration map
  localparam int unsigned COEFF_REGS     = 4;
  localparam int unsigned DEF_MAX_COEFFS = 4;
  localparam int unsigned CFG_W          = 64;
  localparam int unsigned ADDR_W         = 6;
  localparam int unsigned REG_IDX_W      = 3;
  localparam int unsigned COUNT_W        = 3;

  // Reduction: x^64 = x^4 + x^3 + x + 1
  localparam logic [7:0]  FOLD_POLY      = 8'h1B;
  localparam int unsigned FOLD_W         = 4;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ACC_MODE    = 3'd0,
    REG_COEFF_COUNT = 3'd1,
    REG_COEFF_A     = 3'd2,
    REG_COEFF_B     = 3'd3,
    REG_COEFF_C     = 3'd4,
    REG_COEFF_D     = 3'd5
  } reg_idx_e;

  // Payload carried along the cell chain
  typedef struct packed {
    logic [ELEM_W-1:0]   element;
    logic [ELEM_W-1:0]   coeff;
    logic [2*ELEM_W-1:0] acc;
    logic [ELEM_W-1:0]   previous;
    logic                acc_mode;
    logic                last;
  } stage_t;

  // Carry-less product of the element with one coefficient slice
  function automatic logic [ELEM_W+CELL_BITS-1:0] clmul_slice(
    input logic [ELEM_W-1:0]    a,
    input logic [CELL_BITS-1:0] b
  );
    logic [ELEM_W+CELL_BITS-1:0] r;
    r = '0;
    for (int unsigned j = 0; j < CELL_BITS; j++) begin
      if (b[j]) begin
        r = r ^ ({{CELL_BITS{1'b0}}, a} << j);
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/gfrm_cell.sv @@
module gfrm_cell
  import gfrm_pkg::*;
#(
  parameter int unsigned Idx = 0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  stage_t stage_i,
  output logic   valid_o,
  output stage_t stage_o
);

  logic [2*ELEM_W-1:0] part;
  stage_t              stage_d, stage_q;
  logic                valid_q;

  // This cell's share: one coefficient byte, shifted into place
  assign part = {{(ELEM_W-CELL_BITS){1'b0}},
                 clmul_slice(stage_i.element, stage_i.coeff[Idx*CELL_BITS +: CELL_BITS])}
                << (Idx*CELL_BITS);

  always_comb begin
    stage_d     = stage_i;
    stage_d.acc = stage_i.acc ^ part;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

@@ rtl/gfrm_fold.sv @@
module gfrm_fold
  import gfrm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  stage_t            stage_i,
  output logic              done_o,
  output logic [ELEM_W-1:0] product_o,
  output logic              last_o
);

  logic [ELEM_W-1:0]        hi;
  logic [ELEM_W+FOLD_W-1:0] first;
  logic [FOLD_W-1:0]        over;
  logic [2*FOLD_W-1:0]      second;
  logic [ELEM_W-1:0]        product_d, product_q;
  logic                     last_q, done_q;

  always_comb begin
    hi     = stage_i.acc[2*ELEM_W-1:ELEM_W];
    first  = '0;
    second = '0;
    // fold high half by the polynomial tail
    for (int unsigned j = 0; j <= FOLD_W; j++) begin
      if (FOLD_POLY[j]) begin
        first = first ^ ({{FOLD_W{1'b0}}, hi} << j);
      end
    end
    over = first[ELEM_W+FOLD_W-1:ELEM_W];
    // fold the few overflow bits once more
    for (int unsigned j = 0; j <= FOLD_W; j++) begin
      if (FOLD_POLY[j]) begin
        second = second ^ ({{FOLD_W{1'b0}}, over} << j);
      end
    end
    product_d = stage_i.acc[ELEM_W-1:0] ^ first[ELEM_W-1:0]
              ^ {{(ELEM_W-2*FOLD_W){1'b0}}, second};
    if (stage_i.acc_mode) begin
      product_d = product_d ^ stage_i.previous;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      product_q <= product_d;
      last_q    <= stage_i.last;
    end
  end

  assign done_o    = done_q;
  assign product_o = product_q;
  assign last_o    = last_q;

endmodule

@@ rtl/gf64_region_multiply_accumulate.sv @@
// GF(2^64) region multiply / multiply-accumulate, field poly x^64+x^4+x^3+x+1.
//
// Input: an element transfer is taken at a rising edge with start high and
//   busy low. busy never rises: the cell chain takes one element every cycle.
// Output: done_o marks product_o / last_out_o for exactly one cycle. The
//   result of each taken element passes eight multiply cells (one coefficient
//   byte each) and then one reduction register on its way to the ports.
//   Results leave in input order.
// Throughput: one element per cycle, sustained; the chain is fully pipelined.
// Receiver: cannot stall; a result shown with done_o is simply taken.
// Config: APB port, 64-bit registers at byte address 8*index; writes complete
//   in the access cycle (pready is tied high). Registers are accumulate mode,
//   coefficient count and coefficients A..D; only the coefficients that take
//   part are XORed into one multiplier, sampled with each element, so mode
//   and coefficients may only change with the chain empty.
// Reset: rst_ni clears the chain's valid bits and returns the registers to
//   plain mode, count 1 and zero coefficients. No clearing pass is needed.
module gf64_region_multiply_accumulate
  import gfrm_pkg::*;
#(
  parameter int unsigned MAX_COEFFS = DEF_MAX_COEFFS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // element channel
  input  logic              start,
  output logic              busy,
  input  logic [ELEM_W-1:0] element_i,
  input  logic [ELEM_W-1:0] previous_i,
  input  logic              last_in_i,
  // result channel
  output logic              done_o,
  output logic [ELEM_W-1:0] product_o,
  output logic              last_out_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]  pwdata,
  output logic [CFG_W-1:0]  prdata,
  output logic              pready
);

  // Only coefficients that can ever take part are stored
  localparam int unsigned NumRegs = (MAX_COEFFS < COEFF_REGS) ? MAX_COEFFS : COEFF_REGS;

  logic                 acc_mode_q;
  logic [COUNT_W-1:0]   coeff_count_q;
  logic [ELEM_W-1:0]    coeff_q [NumRegs];
  logic [ELEM_W-1:0]    coeff_sum;
  logic                 wr_en;
  reg_idx_e             reg_idx;

  stage_t               stage [NUM_CELLS+1];
  logic [NUM_CELLS:0]   valid;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:ADDR_W-REG_IDX_W]);

  // ---------------------------------------------------------------------------
  // Register file
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_mode_q    <= 1'b0;
      coeff_count_q <= COUNT_W'(1);
      for (int unsigned k = 0; k < NumRegs; k++) begin
        coeff_q[k] <= '0;
      end
    end else if (wr_en) begin
      unique case (reg_idx) inside
        REG_ACC_MODE:    acc_mode_q    <= pwdata[0];
        REG_COEFF_COUNT: coeff_count_q <= pwdata[COUNT_W-1:0];
        [REG_COEFF_A:REG_COEFF_D]: begin
          for (int unsigned k = 0; k < NumRegs; k++) begin
            if (paddr[ADDR_W-1:ADDR_W-REG_IDX_W] ==
                REG_IDX_W'(int'(REG_COEFF_A) + k)) begin
              coeff_q[k] <= pwdata;
            end
          end
        end
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx) inside
      REG_ACC_MODE:    prdata = CFG_W'(acc_mode_q);
      REG_COEFF_COUNT: prdata = CFG_W'(coeff_count_q);
      [REG_COEFF_A:REG_COEFF_D]: begin
        for (int unsigned k = 0; k < NumRegs; k++) begin
          if (paddr[ADDR_W-1:ADDR_W-REG_IDX_W] ==
              REG_IDX_W'(int'(REG_COEFF_A) + k)) begin
            prdata = coeff_q[k];
          end
        end
      end
      default: prdata = '0;
    endcase
  end

  // Sum of products = product with XOR of participating coefficients.
  // A count above the stored set saturates naturally.
  always_comb begin
    coeff_sum = '0;
    for (int unsigned k = 0; k < NumRegs; k++) begin
      if (coeff_count_q > COUNT_W'(k)) begin
        coeff_sum = coeff_sum ^ coeff_q[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain: each cell adds one coefficient byte's partial product
  // ---------------------------------------------------------------------------
  assign valid[0] = start & ~busy;

  always_comb begin
    stage[0]          = '0;
    stage[0].element  = element_i;
    stage[0].coeff    = coeff_sum;
    stage[0].previous = previous_i;
    stage[0].acc_mode = acc_mode_q;
    stage[0].last     = last_in_i;
  end

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    gfrm_cell #(
      .Idx (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[g]),
      .stage_i (stage[g]),
      .valid_o (valid[g+1]),
      .stage_o (stage[g+1])
    );
  end

  // Reduction and accumulate, registered onto the result ports
  gfrm_fold u_fold (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (valid[NUM_CELLS]),
    .stage_i   (stage[NUM_CELLS]),
    .done_o    (done_o),
    .product_o (product_o),
    .last_o    (last_out_o)
  );

endmodule

@@ rtl/gfrm_checker.sv @@
module gfrm_checker
  import gfrm_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic [ELEM_W-1:0] element_i,
  input logic [ELEM_W-1:0] previous_i,
  input logic              last_in_i,
  input logic              done_o,
  input logic [ELEM_W-1:0] product_o,
  input logic              last_out_o
);

  // every accepted element yields a result after the fixed latency
  a_accept_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##PIPE_LAT done_o)
    else $error("accepted element produced no result");

  // no result without a matching accept
  a_done_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, PIPE_LAT))
    else $error("result without accepted element");

  a_last_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (last_out_o == $past(last_in_i, PIPE_LAT)))
    else $error("last flag not carried with its element");

  // a zero element gives zero, or the previous value in accumulate mode
  a_zero_element: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(element_i, PIPE_LAT) == '0)) |->
      ((product_o == '0) || (product_o == $past(previous_i, PIPE_LAT))))
    else $error("zero element gave a nonzero product");

endmodule

bind gf64_region_multiply_accumulate gfrm_checker u_gfrm_checker (.*);
